@@ design/cht_pkg.sv @@
// ============================================================================
// Chained hash table package
// Shared constants, payload types and status codes for the hash table block.
// ============================================================================
package cht_pkg;

    localparam int NumBuckets  = 256;
    localparam int PoolEntries = 1024;
    localparam int BucketW     = $clog2(NumBuckets);
    localparam int NodeW       = $clog2(PoolEntries);
    // A link carries one more bit so that the null link (PoolEntries) fits.
    localparam int LinkW       = NodeW + 1;
    localparam int CountW      = NodeW + 1;
    localparam int CfgW        = 9;

    localparam logic [31:0] HashMult = 32'd2654435761;
    localparam logic [LinkW-1:0] NullLink = LinkW'(PoolEntries);

    // Operation codes.
    localparam logic [1:0] FuncInsert = 2'd0;
    localparam logic [1:0] FuncGet    = 2'd1;
    localparam logic [1:0] FuncPop    = 2'd2;

    // Status codes.
    localparam logic [2:0] StUpdated  = 3'd0;
    localparam logic [2:0] StAdded    = 3'd1;
    localparam logic [2:0] StFull     = 3'd2;
    localparam logic [2:0] StFound    = 3'd3;
    localparam logic [2:0] StNotFound = 3'd4;
    localparam logic [2:0] StRemoved  = 3'd5;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [31:0] value_in;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value_out;
    } t_out_item;

endpackage

@@ design/cht_ram.sv @@
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ============================================================================
module cht_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write first in the array, registered read of the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/cht_mod.sv @@
// ============================================================================
// Bucket index reduction
// Reduces a 32-bit hash modulo the bucket count by restoring subtraction,
// one quotient bit a cycle through a single shared subtractor.
// ============================================================================
module cht_mod
    import cht_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_dividend,
    input  logic [CfgW-1:0]    i_divisor,
    output logic               o_done,
    output logic [BucketW-1:0] o_rem
);

    logic [31:0]   r_dvd, n_dvd;
    logic [CfgW:0] r_rem, n_rem;
    logic [CfgW-1:0] r_dvs, n_dvs;
    logic [5:0]    r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CfgW:0] w_trial;
    logic [CfgW:0] w_diff;

    // One step: shift in the next dividend bit and subtract if it fits.
    assign w_trial = {r_rem[CfgW-1:0], r_dvd[31]};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_comb begin
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
            // Zero is treated as one and large counts saturate.
            if (i_divisor == '0) begin
                n_dvs = CfgW'(1);
            end else if (i_divisor > CfgW'(NumBuckets)) begin
                n_dvs = CfgW'(NumBuckets);
            end else begin
                n_dvs = i_divisor;
            end
        end else if (r_busy) begin
            n_dvd = {r_dvd[30:0], 1'b0};
            n_rem = (w_trial >= {1'b0, r_dvs}) ? w_diff : w_trial;
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[BucketW-1:0];

    // The remainder is always below the divisor once done.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < {1'b0, r_dvs}))
        else $error("remainder out of range");
    // Done is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held");
    // Done only follows a busy step.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without work");

endmodule

@@ design/chained_hash_table_unit.sv @@
// ============================================================================
// Chained hash table unit
// Keyed table of 32-bit keys and values in separately chained buckets.
// ============================================================================
// One item is taken at a time. The key is multiplied by the hash constant,
// then reduced modulo the bucket count by a bit-serial divider. The bucket
// head is read, and the chain is walked one node at a time (a read of the
// key and link memories, then the compare). The next item is taken from the
// cycle the result appears, since a result waiting on the output does not
// hold up the next item until it is itself finished. After reset the bucket
// head memory is cleared by a pass over all NumBuckets entries before the
// first item is taken. Configuration writes are taken only while no item is
// in flight, and an input waits while a configuration write is offered.
// ============================================================================
module chained_hash_table_unit
    import cht_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in_item        i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out_item       o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [CfgW-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_MOD, S_HEAD_RD, S_HEAD_WT, S_NODE_RD,
        S_NODE_CMP, S_FREE_RD, S_ALLOC, S_DONE
    } t_state;

    t_state r_state;
    logic [CfgW-1:0]     r_bcount;
    t_in_item            r_item;
    logic [31:0]         r_hash;
    logic [BucketW-1:0]  r_bucket;
    logic [LinkW-1:0]    r_cur, r_prev;
    logic [CountW-1:0]   r_steps;
    logic [CountW-1:0]   r_fresh, r_recyc;
    logic [BucketW-1:0]  r_clr;
    logic                r_out_valid;
    t_out_item           r_out;
    t_out_item           r_res;
    logic                r_mod_start;

    // Memory ports.
    logic               w_head_we;
    logic [BucketW-1:0] w_head_waddr, w_head_raddr;
    logic [LinkW-1:0]   w_head_wdata, w_head_rdata;
    logic               w_key_we, w_val_we, w_link_we, w_stk_we;
    logic [NodeW-1:0]   w_key_waddr, w_val_waddr, w_link_waddr, w_stk_waddr;
    logic [NodeW-1:0]   w_node_raddr, w_stk_raddr, w_val_raddr;
    logic [31:0]        w_key_wdata, w_val_wdata, w_key_rdata, w_val_rdata;
    logic [LinkW-1:0]   w_link_wdata, w_link_rdata;
    logic [NodeW-1:0]   w_stk_wdata, w_stk_rdata;
    logic               w_mod_done;
    logic [BucketW-1:0] w_mod_rem;
    logic               w_in_xfer, w_hit;
    logic [NodeW-1:0]   w_cur_idx;

    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_cur_idx   = r_cur[NodeW-1:0];
    assign w_hit       = (w_key_rdata == r_item.key);

    cht_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_mod_start),
        .i_dividend (r_hash),
        .i_divisor  (r_bcount),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    cht_ram #(.Width(LinkW), .Depth(NumBuckets)) u_heads (
        .i_clk(i_clk), .i_we(w_head_we), .i_waddr(w_head_waddr),
        .i_wdata(w_head_wdata), .i_raddr(w_head_raddr), .o_rdata(w_head_rdata));
    cht_ram #(.Width(32), .Depth(PoolEntries)) u_keys (
        .i_clk(i_clk), .i_we(w_key_we), .i_waddr(w_key_waddr),
        .i_wdata(w_key_wdata), .i_raddr(w_node_raddr), .o_rdata(w_key_rdata));
    cht_ram #(.Width(32), .Depth(PoolEntries)) u_vals (
        .i_clk(i_clk), .i_we(w_val_we), .i_waddr(w_val_waddr),
        .i_wdata(w_val_wdata), .i_raddr(w_val_raddr), .o_rdata(w_val_rdata));
    cht_ram #(.Width(LinkW), .Depth(PoolEntries)) u_links (
        .i_clk(i_clk), .i_we(w_link_we), .i_waddr(w_link_waddr),
        .i_wdata(w_link_wdata), .i_raddr(w_node_raddr), .o_rdata(w_link_rdata));
    cht_ram #(.Width(NodeW), .Depth(PoolEntries)) u_stack (
        .i_clk(i_clk), .i_we(w_stk_we), .i_waddr(w_stk_waddr),
        .i_wdata(w_stk_wdata), .i_raddr(w_stk_raddr), .o_rdata(w_stk_rdata));

    assign w_node_raddr = w_cur_idx;
    assign w_val_raddr  = w_cur_idx;
    assign w_head_raddr = r_bucket;
    assign w_stk_raddr  = NodeW'(r_recyc - CountW'(1));

    // Write strobes, driven from the state and the compare outcome.
    always_comb begin
        w_head_we    = 1'b0;
        w_head_waddr = r_bucket;
        w_head_wdata = NullLink;
        w_key_we     = 1'b0;
        w_key_waddr  = w_cur_idx;
        w_key_wdata  = r_item.key;
        w_val_we     = 1'b0;
        w_val_waddr  = w_cur_idx;
        w_val_wdata  = r_item.value_in;
        w_link_we    = 1'b0;
        w_link_waddr = r_prev[NodeW-1:0];
        w_link_wdata = w_link_rdata;
        w_stk_we     = 1'b0;
        w_stk_waddr  = r_recyc[NodeW-1:0];
        w_stk_wdata  = w_cur_idx;
        case (r_state)
            S_CLEAR: begin
                w_head_we    = 1'b1;
                w_head_waddr = r_clr;
            end
            S_NODE_CMP: begin
                if (w_hit && r_item.func == FuncInsert) begin
                    w_val_we = 1'b1;
                end else if (w_hit && r_item.func == FuncPop) begin
                    if (r_prev != NullLink) begin
                        w_link_we = 1'b1;
                    end else begin
                        w_head_we    = 1'b1;
                        w_head_wdata = w_link_rdata;
                    end
                    w_stk_we = (r_recyc < CountW'(PoolEntries));
                end
            end
            S_ALLOC: begin
                // r_cur holds the new node, r_prev the old bucket head.
                w_key_we     = 1'b1;
                w_val_we     = 1'b1;
                w_link_we    = 1'b1;
                w_link_waddr = w_cur_idx;
                w_link_wdata = r_prev;
                w_head_we    = 1'b1;
                w_head_wdata = r_cur;
            end
            default: ;
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_bcount    <= CfgW'(NumBuckets);
            r_fresh     <= '0;
            r_recyc     <= '0;
            r_out_valid <= 1'b0;
            r_mod_start <= 1'b0;
        end else begin
            r_mod_start <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bcount <= i_cfg_data;
            end
            // The output register takes a finished item once the previous
            // transfer has gone.
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
                r_out       <= r_res;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + BucketW'(1);
                    if (r_clr == BucketW'(NumBuckets - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_item  <= i_in_data;
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    r_hash      <= r_item.key * HashMult;
                    r_mod_start <= 1'b1;
                    r_state     <= S_MOD;
                end
                S_MOD: begin
                    if (w_mod_done) begin
                        r_bucket <= w_mod_rem;
                        r_state  <= S_HEAD_RD;
                    end
                end
                S_HEAD_RD: begin
                    r_state <= S_HEAD_WT;
                end
                S_HEAD_WT: begin
                    r_cur   <= w_head_rdata;
                    r_prev  <= NullLink;
                    r_steps <= '0;
                    r_state <= S_NODE_RD;
                end
                S_NODE_RD: begin
                    if (r_cur >= NullLink || r_steps >= CountW'(PoolEntries)) begin
                        // Key absent.
                        if (r_item.func == FuncInsert) begin
                            r_state <= S_FREE_RD;
                        end else begin
                            r_res.status    <= StNotFound;
                            r_res.value_out <= '0;
                            r_state         <= S_DONE;
                        end
                    end else begin
                        r_state <= S_NODE_CMP;
                    end
                end
                S_NODE_CMP: begin
                    if (w_hit) begin
                        r_res.value_out <= (r_item.func == FuncGet) ? w_val_rdata : '0;
                        r_state         <= S_DONE;
                        case (r_item.func)
                            FuncInsert: r_res.status <= StUpdated;
                            FuncGet:    r_res.status <= StFound;
                            FuncPop: begin
                                r_res.status <= StRemoved;
                                if (r_recyc < CountW'(PoolEntries)) begin
                                    r_recyc <= r_recyc + CountW'(1);
                                end
                            end
                            default: r_res.status <= StNotFound;
                        endcase
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= w_link_rdata;
                        r_steps <= r_steps + CountW'(1);
                        r_state <= S_NODE_RD;
                    end
                end
                S_FREE_RD: begin
                    // Stack top read is ready; head read from earlier is held.
                    r_prev <= w_head_rdata;
                    if (r_recyc != '0) begin
                        r_cur   <= {1'b0, w_stk_rdata};
                        r_recyc <= r_recyc - CountW'(1);
                        r_state <= S_ALLOC;
                    end else if (r_fresh < CountW'(PoolEntries)) begin
                        r_cur   <= LinkW'(r_fresh);
                        r_fresh <= r_fresh + CountW'(1);
                        r_state <= S_ALLOC;
                    end else begin
                        r_res.status    <= StFull;
                        r_res.value_out <= '0;
                        r_state         <= S_DONE;
                    end
                end
                S_ALLOC: begin
                    r_res.status    <= StAdded;
                    r_res.value_out <= '0;
                    r_state         <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A result is only produced from the final state.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result without finished item");
    // Pool counters never pass the pool size.
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= CountW'(PoolEntries) && r_recyc <= r_fresh)
        else $error("pool counter overflow");
    // No input is taken during the clearing pass.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_in_ready)
        else $error("input during clear");

endmodule
